[hw/rtl/rtpfp_pkg.sv]
// Package for the RTP H.264 fragment packetizer.
// Holds header constants, register indexes and the header field struct.
// No dependencies.
package rtpfp_pkg;

    localparam int LEN_W      = 24;
    localparam int MAXP_W     = 11;
    localparam int PT_W       = 7;
    localparam int SEQ_W      = 16;
    localparam int TS_W       = 32;
    localparam int SSRC_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int HDR_IDX_W  = 4;

    localparam logic [HDR_IDX_W-1:0] HDR_LEN = 4'd14;

    localparam logic [7:0]  RTP_VER_BYTE = 8'h80;
    localparam logic [15:0] FRAG_FIRST   = 16'h1c89;
    localparam logic [15:0] FRAG_MID     = 16'h1c09;
    localparam logic [15:0] FRAG_LAST    = 16'h1c49;

    localparam logic [CFG_IDX_W-1:0] CFG_SSRC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXP = 2'd2;

    localparam logic [SSRC_W-1:0] SSRC_RST = 32'd3334;
    localparam logic [PT_W-1:0]   PT_RST   = 7'd96;
    localparam logic [MAXP_W-1:0] MAXP_RST = 11'd1400;

    // byte positions within the 14-byte header
    localparam logic [HDR_IDX_W-1:0] H_VER   = 4'd0;
    localparam logic [HDR_IDX_W-1:0] H_MPT   = 4'd1;
    localparam logic [HDR_IDX_W-1:0] H_SEQ1  = 4'd2;
    localparam logic [HDR_IDX_W-1:0] H_SEQ0  = 4'd3;
    localparam logic [HDR_IDX_W-1:0] H_TS3   = 4'd4;
    localparam logic [HDR_IDX_W-1:0] H_TS2   = 4'd5;
    localparam logic [HDR_IDX_W-1:0] H_TS1   = 4'd6;
    localparam logic [HDR_IDX_W-1:0] H_TS0   = 4'd7;
    localparam logic [HDR_IDX_W-1:0] H_SS3   = 4'd8;
    localparam logic [HDR_IDX_W-1:0] H_SS2   = 4'd9;
    localparam logic [HDR_IDX_W-1:0] H_SS1   = 4'd10;
    localparam logic [HDR_IDX_W-1:0] H_SS0   = 4'd11;
    localparam logic [HDR_IDX_W-1:0] H_FRAG1 = 4'd12;
    localparam logic [HDR_IDX_W-1:0] H_FRAG0 = 4'd13;

    typedef struct packed {
        logic              marker;
        logic [PT_W-1:0]   pt;
        logic [SEQ_W-1:0]  seq;
        logic [TS_W-1:0]   ts;
        logic [SSRC_W-1:0] ssrc;
        logic [15:0]       frag;
    } t_hdr;

endpackage

[hw/rtl/rtpfp_if.sv]
// Stream interfaces for the packetizer: frame bytes in, packet bytes out.
// Depends on rtpfp_pkg for field widths.
interface rtpfp_in_if;
    logic                          valid;
    logic                          ready;
    logic [7:0]                    data_byte;
    logic [rtpfp_pkg::LEN_W-1:0]   frame_length;
    logic [rtpfp_pkg::TS_W-1:0]    frame_time;

    modport source (output valid, output data_byte, output frame_length,
                    output frame_time, input ready);
    modport sink   (input valid, input data_byte, input frame_length,
                    input frame_time, output ready);
endinterface

interface rtpfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;
    logic       run_end;

    modport source (output valid, output out_byte, output packet_start,
                    output packet_end, output run_end, input ready);
    modport sink   (input valid, input out_byte, input packet_start,
                    input packet_end, input run_end, output ready);
endinterface

[hw/rtl/rtpfp_hdr_mux.sv]
// Header byte selector: picks one of the 14 RTP and fragment header bytes.
// Depends on rtpfp_pkg.
module rtpfp_hdr_mux (
    input  rtpfp_pkg::t_hdr                     i_hdr,
    input  logic [rtpfp_pkg::HDR_IDX_W-1:0]     i_idx,
    output logic [7:0]                          o_byte
);

    always_comb begin
        case (i_idx)
            rtpfp_pkg::H_VER:   o_byte = rtpfp_pkg::RTP_VER_BYTE;
            rtpfp_pkg::H_MPT:   o_byte = {i_hdr.marker, i_hdr.pt};
            rtpfp_pkg::H_SEQ1:  o_byte = i_hdr.seq[15:8];
            rtpfp_pkg::H_SEQ0:  o_byte = i_hdr.seq[7:0];
            rtpfp_pkg::H_TS3:   o_byte = i_hdr.ts[31:24];
            rtpfp_pkg::H_TS2:   o_byte = i_hdr.ts[23:16];
            rtpfp_pkg::H_TS1:   o_byte = i_hdr.ts[15:8];
            rtpfp_pkg::H_TS0:   o_byte = i_hdr.ts[7:0];
            rtpfp_pkg::H_SS3:   o_byte = i_hdr.ssrc[31:24];
            rtpfp_pkg::H_SS2:   o_byte = i_hdr.ssrc[23:16];
            rtpfp_pkg::H_SS1:   o_byte = i_hdr.ssrc[15:8];
            rtpfp_pkg::H_SS0:   o_byte = i_hdr.ssrc[7:0];
            rtpfp_pkg::H_FRAG1: o_byte = i_hdr.frag[15:8];
            rtpfp_pkg::H_FRAG0: o_byte = i_hdr.frag[7:0];
            default:            o_byte = 8'h00;
        endcase
    end

endmodule

[hw/rtl/rtp_h264_fragment_packetizer.sv]
// Top level of the RTP H.264 fragment packetizer.
// Depends on rtpfp_pkg, rtpfp_if (stream interfaces) and rtpfp_hdr_mux.
//
// Usage:
//   i_in carries frame bytes with the frame length and RTP timestamp; o_out
//   carries the packet stream, one byte per transfer, flagged with
//   packet_start (first RTP header byte), packet_end (last payload byte)
//   and run_end (last byte caused by one input byte).
//   Configuration (SSRC, payload type, max payload) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
//   An accepted byte is decided at once (packet open, last packet, frame
//   end) and parked in a job register; the job then emits one byte per
//   cycle into the output register while that register can take it: 15
//   bytes when a packet opens (12 RTP header, 2 fragment header, payload),
//   otherwise the payload byte alone. Inside a packet one input byte is
//   taken per cycle while the output does not stall; an opening byte holds
//   the job for its 15 bytes, set by the single output byte lane. A new
//   input is taken in the cycle the job hands over its last byte.
//   Reset clears the frame offset, packet fill and sequence number and
//   restores the register defaults; no output is pending afterwards.
//   When the receiver stalls, the output register holds its byte and the
//   job and input sides stall behind it; nothing is dropped.
module rtp_h264_fragment_packetizer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    rtpfp_in_if.sink                             i_in,
    rtpfp_out_if.source                          o_out,
    input  logic                                 i_cfg_we,
    input  logic [rtpfp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rtpfp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int LW = rtpfp_pkg::LEN_W;
    localparam int MW = rtpfp_pkg::MAXP_W;

    // configuration
    logic [rtpfp_pkg::SSRC_W-1:0] r_ssrc;
    logic [rtpfp_pkg::PT_W-1:0]   r_pt;
    logic [MW-1:0]                r_maxp;

    // running state
    logic [LW-1:0]                r_off,  n_off;
    logic [MW-1:0]                r_fill, n_fill;
    logic [rtpfp_pkg::SEQ_W-1:0]  r_seq,  n_seq;

    // job register
    logic                         r_jv, n_jv;
    logic                         r_jhdr;
    logic [rtpfp_pkg::HDR_IDX_W-1:0] r_idx, n_idx;
    logic [7:0]                   r_jbyte;
    logic                         r_jend;
    rtpfp_pkg::t_hdr              r_hdr;

    // output register
    logic                         r_ov, n_ov;
    logic [7:0]                   r_obyte;
    logic                         r_ostart, r_oend, r_orun;

    logic [MW-1:0]  mp;
    logic           pkt_open, last_pkt, frame_done, pkt_done;
    logic           in_xfer, emit, job_done, emit_hdr;
    logic [7:0]     hdr_byte;
    logic [15:0]    frag;
    logic           marker;
    rtpfp_pkg::t_hdr hdr_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ssrc <= rtpfp_pkg::SSRC_RST;
            r_pt   <= rtpfp_pkg::PT_RST;
            r_maxp <= rtpfp_pkg::MAXP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rtpfp_pkg::CFG_SSRC: r_ssrc <= i_cfg_data;
                rtpfp_pkg::CFG_PT:   r_pt   <= i_cfg_data[rtpfp_pkg::PT_W-1:0];
                rtpfp_pkg::CFG_MAXP: r_maxp <= i_cfg_data[MW-1:0];
                default: ;
            endcase
        end
    end

    // packet decision for the incoming byte
    always_comb begin
        mp         = (r_maxp == '0) ? MW'(1) : r_maxp;
        pkt_open   = (r_fill == '0);
        last_pkt   = ({1'b0, r_off} + {{(LW + 1 - MW){1'b0}}, mp})
                     >= {1'b0, i_in.frame_length};
        frame_done = ({1'b0, r_off} + (LW + 1)'(1)) >= {1'b0, i_in.frame_length};
        pkt_done   = frame_done || (({1'b0, r_fill} + (MW + 1)'(1)) >= {1'b0, mp});
        if (last_pkt) begin
            frag   = rtpfp_pkg::FRAG_LAST;
            marker = 1'b1;
        end else if (r_off == '0) begin
            frag   = rtpfp_pkg::FRAG_FIRST;
            marker = 1'b1;
        end else begin
            frag   = rtpfp_pkg::FRAG_MID;
            marker = 1'b0;
        end
        hdr_in.marker = marker;
        hdr_in.pt     = r_pt;
        hdr_in.seq    = r_seq;
        hdr_in.ts     = i_in.frame_time;
        hdr_in.ssrc   = r_ssrc;
        hdr_in.frag   = frag;
    end

    // job sequencing
    always_comb begin
        emit     = r_jv && (!r_ov || o_out.ready);
        emit_hdr = r_jhdr && (r_idx != rtpfp_pkg::HDR_LEN);
        job_done = emit && !emit_hdr;
        i_in.ready = !r_jv || job_done;
        in_xfer  = i_in.valid && i_in.ready;

        n_off  = r_off;
        n_fill = r_fill;
        n_seq  = r_seq;
        if (in_xfer) begin
            n_off  = frame_done ? '0 : r_off + LW'(1);
            n_fill = pkt_done ? '0 : r_fill + MW'(1);
            if (pkt_open) begin
                n_seq = r_seq + rtpfp_pkg::SEQ_W'(1);
            end
        end

        n_jv  = in_xfer ? 1'b1 : (job_done ? 1'b0 : r_jv);
        n_idx = r_idx;
        if (in_xfer) begin
            n_idx = '0;
        end else if (emit && emit_hdr) begin
            n_idx = r_idx + rtpfp_pkg::HDR_IDX_W'(1);
        end

        n_ov = emit ? 1'b1 : (o_out.ready ? 1'b0 : r_ov);
    end

    rtpfp_hdr_mux u_hdr_mux (
        .i_hdr  (r_hdr),
        .i_idx  (r_idx),
        .o_byte (hdr_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= '0;
            r_fill <= '0;
            r_seq  <= '0;
            r_jv   <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_off  <= n_off;
            r_fill <= n_fill;
            r_seq  <= n_seq;
            r_jv   <= n_jv;
            r_ov   <= n_ov;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_jhdr  <= pkt_open;
            r_jbyte <= i_in.data_byte;
            r_jend  <= pkt_done;
            r_hdr   <= hdr_in;
        end
        if (emit) begin
            if (emit_hdr) begin
                r_obyte  <= hdr_byte;
                r_ostart <= (r_idx == rtpfp_pkg::H_VER);
                r_oend   <= 1'b0;
                r_orun   <= 1'b0;
            end else begin
                r_obyte  <= r_jbyte;
                r_ostart <= 1'b0;
                r_oend   <= r_jend;
                r_orun   <= 1'b1;
            end
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.out_byte     = r_obyte;
    assign o_out.packet_start = r_ostart;
    assign o_out.packet_end   = r_oend;
    assign o_out.run_end      = r_orun;

endmodule

[test/rtpfp_stream_check.sv]
// Scoreboard for the RTP H.264 fragment packetizer: follows config writes and
// input transfers, predicts the packet byte stream and compares each output transfer.
// Depends on rtpfp_pkg and the stream interfaces in rtpfp_if.
module rtpfp_stream_check (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rtpfp_in_if                              i_in,
    rtpfp_out_if                             i_out,
    input  logic                             i_cfg_we,
    input  logic [rtpfp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rtpfp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rtpfp_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_start;
        logic       packet_end;
        logic       run_end;
    } t_pkt_byte;

    t_pkt_byte         packet_bytes_due[$];
    logic [SSRC_W-1:0] ssrc;
    logic [PT_W-1:0]   pt;
    logic [MAXP_W-1:0] maxp;
    logic [LEN_W-1:0]  frame_offset;
    logic [SEQ_W-1:0]  seq_num;
    logic [MAXP_W-1:0] packet_fill;
    int                fails = 0;

    task automatic packetize_byte(input logic [7:0] data, input logic [LEN_W-1:0] flen,
                                  input logic [TS_W-1:0] ts);
        logic [MAXP_W-1:0] limit;
        logic [15:0]       frag;
        logic              marker;
        logic [111:0]      hdr;
        logic              frame_done;
        logic              pkt_done;
        limit = (maxp == '0) ? MAXP_W'(1) : maxp;
        if (packet_fill == '0) begin
            if (({1'b0, frame_offset} + limit) >= flen) begin
                frag   = FRAG_LAST;
                marker = 1'b1;
            end else if (frame_offset == '0) begin
                frag   = FRAG_FIRST;
                marker = 1'b1;
            end else begin
                frag   = FRAG_MID;
                marker = 1'b0;
            end
            hdr = {RTP_VER_BYTE, marker, pt, seq_num, ts, ssrc, frag};
            for (int i = 0; i < 14; i++) begin
                packet_bytes_due.push_back('{out_byte: hdr[111 - 8*i -: 8],
                                             packet_start: (i == 0),
                                             packet_end: 1'b0, run_end: 1'b0});
            end
            seq_num = seq_num + 1'b1;
        end
        frame_done = ({1'b0, frame_offset} + 1) >= flen;
        pkt_done   = frame_done || (({1'b0, packet_fill} + 1) >= limit);
        packet_bytes_due.push_back('{out_byte: data, packet_start: 1'b0,
                                     packet_end: pkt_done, run_end: 1'b1});
        frame_offset = frame_done ? '0 : frame_offset + 1'b1;
        packet_fill  = pkt_done ? '0 : packet_fill + 1'b1;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v, act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pkt_byte due;
        if (!i_rst_n) begin
            ssrc         = SSRC_RST;
            pt           = PT_RST;
            maxp         = MAXP_RST;
            frame_offset = '0;
            seq_num      = '0;
            packet_fill  = '0;
            packet_bytes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SSRC: ssrc = i_cfg_data[SSRC_W-1:0];
                    CFG_PT:   pt   = i_cfg_data[PT_W-1:0];
                    CFG_MAXP: maxp = i_cfg_data[MAXP_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                packetize_byte(i_in.data_byte, i_in.frame_length, i_in.frame_time);
            end
            if (i_out.valid && i_out.ready) begin
                if (packet_bytes_due.size() == 0) begin
                    $error("unexpected output transfer: byte %0h", i_out.out_byte);
                    fails++;
                end else begin
                    due = packet_bytes_due.pop_front();
                    check_field("out_byte", due.out_byte, i_out.out_byte);
                    check_field("packet_start", due.packet_start, i_out.packet_start);
                    check_field("packet_end", due.packet_end, i_out.packet_end);
                    check_field("run_end", due.run_end, i_out.run_end);
                end
            end
        end
        o_pending    <= packet_bytes_due.size();
        o_fail_count <= fails;
    end

endmodule

[test/tb.sv]
// Testbench top for the RTP H.264 fragment packetizer: drives frame bytes and
// config writes with random gaps and back-pressure, and reports the verdict.
// Depends on rtpfp_pkg, rtpfp_if, the packetizer RTL and rtpfp_stream_check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rtpfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    fail_count;
    int                    items_sent = 0;
    bit                    no_idle = 1'b0;
    int unsigned           cycle_count = 0;

    rtpfp_in_if  in_ch ();
    rtpfp_out_if out_ch ();

    rtp_h264_fragment_packetizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rtpfp_stream_check stream_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [MAXP_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return 11'd2047;
        if (r == 2) return MAXP_W'($urandom_range(0, 2047));
        return MAXP_W'($urandom_range(1, 12));
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic [LEN_W-1:0] flen,
                             input logic [TS_W-1:0] ts);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= data;
        in_ch.frame_length <= flen;
        in_ch.frame_time   <= ts;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_frame(input logic [LEN_W-1:0] flen, input int count,
                              input logic [TS_W-1:0] ts);
        for (int i = 0; i < count; i++) send_byte(8'($urandom_range(0, 255)), flen, ts);
    endtask

    // wait until every predicted byte has been seen on the output
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [SSRC_W-1:0] ssrc, input logic [PT_W-1:0] pt,
                             input logic [MAXP_W-1:0] maxp);
        put_reg(CFG_SSRC, ssrc);
        put_reg(CFG_PT, CFG_DATA_W'(pt));
        put_reg(CFG_MAXP, CFG_DATA_W'(maxp));
        cfg_we <= 1'b0;
    endtask

    // output side: random ready pattern plus one long hold-off
    initial begin
        int  hold;
        int  transfers;
        int  gap;
        bit  long_done;
        hold         = 0;
        transfers    = 0;
        long_done    = 1'b0;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) transfers++;
            if (hold > 0) begin
                hold--;
            end else if (!long_done && transfers >= 1000 && in_ch.valid) begin
                out_ch.ready <= 1'b0;
                hold      = 600;
                long_done = 1'b1;
            end else if (!out_ch.ready) begin
                out_ch.ready <= 1'b1;
                hold = $urandom_range(0, 16);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    hold = gap - 1;
                end else begin
                    hold = $urandom_range(0, 16);
                end
            end
        end
    end

    initial begin
        logic [LEN_W-1:0] carry_len;
        logic [TS_W-1:0]  carry_ts;
        logic [LEN_W-1:0] flen;
        int               carry_left;
        int               nframes;
        int               kind;
        int               cnt;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.frame_length = '0;
        in_ch.frame_time   = '0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        i_rst_n            = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, single-packet frame
        send_frame(24'd3, 3, 32'h0000_0000);
        // zero limit acts as one byte per packet; field extremes
        drain();
        configure(32'hFFFF_FFFF, 7'h7f, 11'd0);
        send_byte(8'hFF, 24'd2, 32'hFFFF_FFFF);
        send_byte(8'h00, 24'd2, 32'hFFFF_FFFF);
        // zero frame length
        send_byte(8'h5a, 24'd0, 32'h1234_5678);
        // first, middle and last packets
        drain();
        configure(32'h0000_0000, 7'h00, 11'd2);
        send_frame(24'd5, 5, 32'h8000_0001);
        // frame length shrinks mid-frame
        drain();
        configure(32'hA5C3_0F81, 7'h55, 11'd4);
        send_byte(8'h81, 24'hFF_FFFF, 32'h0BAD_F00D);
        send_byte(8'h7e, 24'd2, 32'h0BAD_F00D);
        // limit lowered while a packet is open
        send_frame(24'd6, 2, 32'h0000_0100);
        drain();
        configure(32'hA5C3_0F81, 7'h55, 11'd1);
        send_frame(24'd6, 4, 32'h0000_0100);
        drain();
        configure(32'h1357_9BDF, 7'h2a, 11'd2047);
        send_frame(24'd4, 4, 32'h0000_0200);

        carry_left = 0;
        while (items_sent < 345) begin
            drain();
            no_idle = ($urandom_range(0, 3) == 0);
            configure($urandom(), 7'($urandom_range(0, 127)), pick_limit());
            if (carry_left > 0) send_frame(carry_len, carry_left, carry_ts);
            carry_left = 0;
            nframes = $urandom_range(1, 5);
            for (int f = 0; f < nframes; f++) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    flen = LEN_W'($urandom_range(1, 40));
                    cnt  = flen;
                    if (f == nframes - 1 && $urandom_range(0, 2) == 0) begin
                        cnt        = $urandom_range(1, flen);
                        carry_len  = flen;
                        carry_left = flen - cnt;
                        carry_ts   = $urandom();
                        send_frame(flen, cnt, carry_ts);
                    end else begin
                        send_frame(flen, cnt, $urandom());
                    end
                end else if (kind < 9) begin
                    // noise, then a one-byte frame to get back in step
                    repeat ($urandom_range(1, 4)) begin
                        flen = $urandom_range(0, 1) ? LEN_W'($urandom_range(0, 24'hFF_FFFF))
                                                    : LEN_W'($urandom_range(0, 3));
                        send_byte(8'($urandom_range(0, 255)), flen, $urandom());
                    end
                    send_byte(8'($urandom_range(0, 255)), 24'd1, $urandom());
                end else begin
                    flen = LEN_W'($urandom_range(41, 120));
                    send_frame(flen, flen, $urandom());
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
